[rtl/vcfp_pkg.sv]
`default_nettype none
package vcfp_pkg;

    localparam int MAX_STATES = 16;
    localparam int PROB_BITS  = 16;
    localparam int STATE_BITS = $clog2(MAX_STATES);
    localparam int ADDR_BITS  = 2 * STATE_BITS;
    localparam int COUNT_BITS = $clog2(MAX_STATES + 1);
    localparam int SUM_BITS   = PROB_BITS + STATE_BITS;
    localparam int LIMIT_BITS = 10;
    localparam int CFG_BITS   = 10;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_STATES_IN_USE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DRAW_LIMIT    = 2'd1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_DRAW  = 1'b1;

    localparam logic [COUNT_BITS-1:0] STATES_RESET = COUNT_BITS'(16);
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET  = LIMIT_BITS'(99);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                  init;
        logic                  step;
        logic [STATE_BITS-1:0] row;
        logic [STATE_BITS-1:0] target;
        logic                  commit;
    } map_ctrl_t;

endpackage
`default_nettype wire

[rtl/vcfp_table.sv]
`default_nettype none
module vcfp_table (
    input  wire logic                           clk,
    input  wire logic                           wr_en,
    input  wire logic [vcfp_pkg::ADDR_BITS-1:0] wr_addr,
    input  wire logic [vcfp_pkg::PROB_BITS-1:0] wr_data,
    input  wire logic [vcfp_pkg::ADDR_BITS-1:0] rd_addr,
    output logic      [vcfp_pkg::PROB_BITS-1:0] rd_data
);
    import vcfp_pkg::*;

    logic [PROB_BITS-1:0] mem [MAX_STATES*MAX_STATES];
    logic [PROB_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[rtl/vcfp_cdf_unit.sv]
`default_nettype none
module vcfp_cdf_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire logic                           first,
    input  wire logic [vcfp_pkg::PROB_BITS-1:0] data,
    input  wire logic [vcfp_pkg::PROB_BITS-1:0] threshold,
    output logic                                hit
);
    import vcfp_pkg::*;

    logic [SUM_BITS-1:0] sum_reg;
    logic [SUM_BITS-1:0] sum_next;

    // The running sum restarts at the first column of every row.
    always_comb
    begin
        sum_next = (first ? '0 : sum_reg) + SUM_BITS'(data);
        hit      = sum_next > SUM_BITS'(threshold);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (en)
        begin
            sum_reg <= sum_next;
        end
    end

endmodule
`default_nettype wire

[rtl/vcfp_map_store.sv]
`default_nettype none
module vcfp_map_store (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire vcfp_pkg::map_ctrl_t             ctrl,
    input  wire logic [vcfp_pkg::STATE_BITS-1:0] last_state,
    output logic                                 coalesced,
    output logic      [vcfp_pkg::STATE_BITS-1:0] head_state
);
    import vcfp_pkg::*;

    logic [STATE_BITS-1:0] map_reg  [MAX_STATES];
    logic [STATE_BITS-1:0] next_reg [MAX_STATES];

    // The next map always starts equal to the current one, so states out of use carry over.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STATES; i++)
            begin
                map_reg[i]  <= STATE_BITS'(i);
                next_reg[i] <= STATE_BITS'(i);
            end
        end
        else if (ctrl.init)
        begin
            for (int i = 0; i < MAX_STATES; i++)
            begin
                map_reg[i]  <= STATE_BITS'(i);
                next_reg[i] <= STATE_BITS'(i);
            end
        end
        else if (ctrl.commit)
        begin
            for (int i = 0; i < MAX_STATES; i++)
            begin
                map_reg[i] <= next_reg[i];
            end
        end
        else if (ctrl.step)
        begin
            next_reg[ctrl.row] <= map_reg[ctrl.target];
        end
    end

    always_comb
    begin
        coalesced = 1'b1;
        for (int i = 1; i < MAX_STATES; i++)
        begin
            if ((STATE_BITS'(i) <= last_state) && (next_reg[i] != next_reg[0]))
            begin
                coalesced = 1'b0;
            end
        end
        head_state = next_reg[0];
    end

endmodule
`default_nettype wire

[rtl/voter_coupling_from_past_sampler_top.sv]
`default_nettype none
// Table write: result strobe in the cycle after the transfer; busy stays low, next item at once.
// Draw: the scan reads one table entry at a time, each row stopping at its first hit or its last
// active column, then the finish state follows; the table's single read port sets that pace.
// The result strobe follows the finish cycle; busy is high from the transfer until then.
// Results are never stalled. Reset clears the map to identity, the draw count to zero and
// the registers to 16 states and a limit of 99; the table is undefined until written.
module voter_coupling_from_past_sampler_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           operation,
    input  wire logic [vcfp_pkg::STATE_BITS-1:0] from_state,
    input  wire logic [vcfp_pkg::STATE_BITS-1:0] to_state,
    input  wire logic [vcfp_pkg::PROB_BITS-1:0] probability,
    input  wire logic [vcfp_pkg::PROB_BITS-1:0] uniform_draw,
    input  wire logic                           cfg_write,
    input  wire logic [vcfp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [vcfp_pkg::CFG_BITS-1:0]  cfg_data,
    output logic                                result_valid,
    output logic                                sample_ready,
    output logic      [vcfp_pkg::STATE_BITS-1:0] sample_state,
    output logic                                attempt_failed
);
    import vcfp_pkg::*;

    state_t                state_reg, state_next;
    logic [STATE_BITS-1:0] row_reg, row_next;
    logic [STATE_BITS-1:0] col_reg, col_next;
    logic [PROB_BITS-1:0]  r_reg, r_next;
    logic [LIMIT_BITS-1:0] draws_reg, draws_next;
    logic                  valid_reg, valid_next;
    logic                  ready_reg, ready_next;
    logic [STATE_BITS-1:0] sstate_reg, sstate_next;
    logic                  failed_reg, failed_next;

    logic [COUNT_BITS-1:0] states_in_use_reg;
    logic [LIMIT_BITS-1:0] draw_limit_reg;

    logic                  accept;
    logic [COUNT_BITS-1:0] n_active;
    logic [STATE_BITS-1:0] last_state;
    logic [LIMIT_BITS-1:0] limit;
    logic [LIMIT_BITS-1:0] draws_inc;
    logic [PROB_BITS-1:0]  table_data;
    logic                  hit;
    logic                  cdf_en;
    logic                  coalesced;
    logic [STATE_BITS-1:0] head_state;
    map_ctrl_t             map_ctrl;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        if (states_in_use_reg < COUNT_BITS'(2))
            n_active = COUNT_BITS'(2);
        else if (states_in_use_reg > COUNT_BITS'(MAX_STATES))
            n_active = COUNT_BITS'(MAX_STATES);
        else
            n_active = states_in_use_reg;
        last_state = STATE_BITS'(n_active - COUNT_BITS'(1));
        limit      = (draw_limit_reg == '0) ? LIMIT_BITS'(1) : draw_limit_reg;
        draws_inc  = draws_reg + LIMIT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            states_in_use_reg <= STATES_RESET;
            draw_limit_reg    <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_STATES_IN_USE: states_in_use_reg <= COUNT_BITS'(cfg_data);
                CFG_DRAW_LIMIT:    draw_limit_reg    <= LIMIT_BITS'(cfg_data);
                default:           ;
            endcase
        end
    end

    vcfp_table u_table (
        .clk     (clk),
        .wr_en   (accept && (operation == OP_WRITE)),
        .wr_addr ({from_state, to_state}),
        .wr_data (probability),
        .rd_addr ({row_next, col_next}),
        .rd_data (table_data)
    );

    vcfp_cdf_unit u_cdf (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (cdf_en),
        .first     (col_reg == '0),
        .data      (table_data),
        .threshold (r_reg),
        .hit       (hit)
    );

    vcfp_map_store u_map (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (map_ctrl),
        .last_state (last_state),
        .coalesced  (coalesced),
        .head_state (head_state)
    );

    always_comb
    begin
        state_next  = state_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        r_next      = r_reg;
        draws_next  = draws_reg;
        valid_next  = 1'b0;
        ready_next  = 1'b0;
        sstate_next = '0;
        failed_next = 1'b0;
        cdf_en      = 1'b0;
        map_ctrl    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_DRAW)
                    begin
                        r_next     = uniform_draw;
                        row_next   = '0;
                        col_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        valid_next = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cdf_en = 1'b1;
                // The target is the current column both on a hit and on running off the row.
                if (hit || (col_reg == last_state))
                begin
                    map_ctrl.step   = 1'b1;
                    map_ctrl.row    = row_reg;
                    map_ctrl.target = col_reg;
                    if (row_reg == last_state)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        row_next = row_reg + STATE_BITS'(1);
                        col_next = '0;
                    end
                end
                else
                begin
                    col_next = col_reg + STATE_BITS'(1);
                end
            end
            ST_FINISH:
            begin
                valid_next = 1'b1;
                state_next = ST_IDLE;
                if (coalesced)
                begin
                    ready_next    = 1'b1;
                    sstate_next   = head_state;
                    map_ctrl.init = 1'b1;
                    draws_next    = '0;
                end
                else if (draws_inc >= limit)
                begin
                    failed_next   = 1'b1;
                    map_ctrl.init = 1'b1;
                    draws_next    = '0;
                end
                else
                begin
                    map_ctrl.commit = 1'b1;
                    draws_next      = draws_inc;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            draws_reg  <= '0;
            valid_reg  <= 1'b0;
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            draws_reg  <= draws_next;
            valid_reg  <= valid_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        ready_reg  <= ready_next;
        sstate_reg <= sstate_next;
        failed_reg <= failed_next;
    end

    assign result_valid   = valid_reg;
    assign sample_ready   = ready_reg;
    assign sample_state   = sstate_reg;
    assign attempt_failed = failed_reg;

endmodule
`default_nettype wire
